@@ hw/rtl/rrfb_pkg.sv @@
// rrfb_pkg: constants, types and the crc byte update shared by the report frame builder
// no dependencies; compiled first
package rrfb_pkg;

    // store depth and derived widths
    localparam int MAX_NODES = 16;
    localparam int PTR_W     = $clog2(MAX_NODES);
    // pointer arithmetic must hold own id (8 bits) and the pointer plus two
    localparam int P_W       = ($clog2(MAX_NODES + 2) > 9) ? $clog2(MAX_NODES + 2) : 9;

    // frame layout
    localparam int FRAME_LEN = 10;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_FIRST    = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_HDR0     = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_HDR1     = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_HDR2     = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_NODE     = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_STRENGTH = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_NOISE    = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_CRC_LO   = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_CRC_HI   = IDX_W'(8);
    // six message bytes plus the extra byte
    localparam logic [IDX_W-1:0] CRC_LAST_STEP = IDX_W'(6);

    localparam logic [9:0]  MIN_SPACE  = 10'd10;
    localparam logic [7:0]  HDR_START  = 8'd3;
    localparam logic [7:0]  HDR_MSG_ID = 8'd2;
    localparam logic [7:0]  CRC_EXTRA  = 8'd116;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;

    // item kinds
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // register map: index = paddr / 4
    localparam int   ADDR_W         = 3;
    localparam logic REG_OWN_ID     = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;
    localparam logic [4:0] NODE_COUNT_RESET = 5'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_COBS,
        S_SEND
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             crc_step;
        logic             cobs_step;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic report_ok;
    } t_dp_status;

    // mcrf4xx byte update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [15:0] tw;
        t  = b ^ crc[7:0];
        t  = t ^ {t[3:0], 4'b0000};
        tw = {8'h00, t};
        return {8'h00, crc[15:8]} ^ (tw << 8) ^ (tw << 3) ^ (tw >> 4);
    endfunction

endpackage

@@ hw/rtl/rrfb_in_if.sv @@
// rrfb_in_if: valid/ready channel carrying one record or report request item
// no dependencies
interface rrfb_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] node;
    logic [7:0] strength;
    logic [7:0] noise;
    logic [9:0] tx_space;

    modport source(output valid, output mode, output node, output strength,
                   output noise, output tx_space, input ready);
    modport sink(input valid, input mode, input node, input strength,
                 input noise, input tx_space, output ready);
endinterface

@@ hw/rtl/rrfb_out_if.sv @@
// rrfb_out_if: valid/ready channel carrying one encoded frame byte item
// no dependencies
interface rrfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source(output valid, output frame_byte, output last, input ready);
    modport sink(input valid, input frame_byte, input last, output ready);
endinterface

@@ hw/rtl/rrfb_ctrl.sv @@
// rrfb_ctrl: sequencer for accept, crc, cobs and send phases
// depends on rrfb_pkg
module rrfb_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output logic                     o_out_last,
    input  logic                     i_out_ready,
    input  rrfb_pkg::t_dp_status     i_status,
    output rrfb_pkg::t_dp_cmd        o_cmd
);

    rrfb_pkg::t_state r_state, n_state;
    logic [rrfb_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic accept;

    assign accept = i_in_valid && (r_state == rrfb_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrfb_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrfb_pkg::S_IDLE: begin
                if (accept && i_status.report_ok) n_state = rrfb_pkg::S_CRC;
            end
            rrfb_pkg::S_CRC: begin
                if (r_cnt == rrfb_pkg::CRC_LAST_STEP) n_state = rrfb_pkg::S_COBS;
            end
            rrfb_pkg::S_COBS: begin
                if (r_cnt == rrfb_pkg::IDX_LAST) n_state = rrfb_pkg::S_SEND;
            end
            rrfb_pkg::S_SEND: begin
                if (i_out_ready && r_cnt == rrfb_pkg::IDX_LAST) n_state = rrfb_pkg::S_IDLE;
            end
            default: n_state = rrfb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_out_last      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.crc_step  = 1'b0;
        o_cmd.cobs_step = 1'b0;
        o_cmd.idx       = r_cnt;
        n_cnt           = r_cnt;
        unique case (r_state)
            rrfb_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = accept;
                n_cnt        = '0;
            end
            rrfb_pkg::S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (r_cnt == rrfb_pkg::CRC_LAST_STEP) begin
                    n_cnt = rrfb_pkg::IDX_FIRST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rrfb_pkg::S_COBS: begin
                o_cmd.cobs_step = 1'b1;
                if (r_cnt == rrfb_pkg::IDX_LAST) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rrfb_pkg::S_SEND: begin
                o_out_valid = 1'b1;
                o_out_last  = (r_cnt == rrfb_pkg::IDX_LAST);
                if (i_out_ready) n_cnt = r_cnt + 1'b1;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/rrfb_datapath.sv @@
// rrfb_datapath: strength store, node pointer, frame buffer, crc and cobs step logic
// depends on rrfb_pkg; driven by rrfb_ctrl commands
module rrfb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrfb_pkg::t_dp_cmd    i_cmd,
    output rrfb_pkg::t_dp_status o_status,
    input  logic                 i_mode,
    input  logic [3:0]           i_node,
    input  logic [7:0]           i_strength,
    input  logic [7:0]           i_noise,
    input  logic [9:0]           i_tx_space,
    input  logic [7:0]           i_own_id,
    input  logic [4:0]           i_node_count,
    output logic [7:0]           o_frame_byte
);

    localparam int P_W   = rrfb_pkg::P_W;
    localparam int IDX_W = rrfb_pkg::IDX_W;

    logic [rrfb_pkg::PTR_W-1:0] r_ptr;
    logic [7:0]  r_store [rrfb_pkg::MAX_NODES];
    logic [7:0]  r_fb    [rrfb_pkg::FRAME_LEN];
    logic [15:0] r_crc;
    logic [IDX_W-1:0] r_run;

    logic [P_W-1:0] p_inc, p_skip, p_wrap;
    logic [rrfb_pkg::PTR_W-1:0] p_idx;
    logic [7:0]  crc_in;
    logic [15:0] crc_next;
    logic [IDX_W-1:0] run_next;
    logic record_go, report_go;

    assign o_status.report_ok = (i_mode == rrfb_pkg::MODE_REPORT) &&
                                (i_tx_space >= rrfb_pkg::MIN_SPACE);
    assign record_go = i_cmd.accept && (i_mode == rrfb_pkg::MODE_RECORD) &&
                       (P_W'(i_node) < P_W'(rrfb_pkg::MAX_NODES));
    assign report_go = i_cmd.accept && o_status.report_ok;

    // next pointer: increment, single own-id skip, then wrap
    always_comb begin
        p_inc  = P_W'(r_ptr) + P_W'(1);
        p_skip = (p_inc == P_W'(i_own_id)) ? p_inc + P_W'(1) : p_inc;
        if (p_skip >= P_W'(i_node_count) || p_skip >= P_W'(rrfb_pkg::MAX_NODES)) begin
            p_wrap = '0;
        end else begin
            p_wrap = p_skip;
        end
        p_idx = p_wrap[rrfb_pkg::PTR_W-1:0];
    end

    // crc runs over buffer bytes 1..6, then the extra byte
    always_comb begin
        if (i_cmd.idx == rrfb_pkg::CRC_LAST_STEP) begin
            crc_in = rrfb_pkg::CRC_EXTRA;
        end else begin
            crc_in = r_fb[i_cmd.idx + 1'b1];
        end
        crc_next = rrfb_pkg::crc_byte(r_crc, crc_in);
        run_next = r_run + 1'b1;
    end

    assign o_frame_byte = r_fb[i_cmd.idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            for (int k = 0; k < rrfb_pkg::MAX_NODES; k++) r_store[k] <= '0;
        end else if (record_go) begin
            r_store[rrfb_pkg::PTR_W'(i_node)] <= i_strength;
        end else if (report_go) begin
            r_ptr          <= p_idx;
            r_store[p_idx] <= '0;
        end
    end

    // frame buffer, crc and run length: payload, no reset
    always_ff @(posedge i_clk) begin
        if (report_go) begin
            r_fb[0]                      <= 8'h00;
            r_fb[rrfb_pkg::IDX_HDR0]     <= rrfb_pkg::HDR_START;
            r_fb[rrfb_pkg::IDX_HDR1]     <= i_own_id;
            r_fb[rrfb_pkg::IDX_HDR2]     <= rrfb_pkg::HDR_MSG_ID;
            r_fb[rrfb_pkg::IDX_NODE]     <= p_wrap[7:0];
            r_fb[rrfb_pkg::IDX_STRENGTH] <= r_store[p_idx];
            r_fb[rrfb_pkg::IDX_NOISE]    <= i_noise;
            r_fb[rrfb_pkg::IDX_LAST]     <= 8'h00;
            r_crc                        <= rrfb_pkg::CRC_SEED;
            r_run                        <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc <= crc_next;
            if (i_cmd.idx == rrfb_pkg::CRC_LAST_STEP) begin
                r_fb[rrfb_pkg::IDX_CRC_LO] <= crc_next[7:0];
                r_fb[rrfb_pkg::IDX_CRC_HI] <= crc_next[15:8];
            end
        end else if (i_cmd.cobs_step) begin
            // a zero takes the distance back to the previous code slot
            if (r_fb[i_cmd.idx] == 8'h00) begin
                r_fb[i_cmd.idx - run_next] <= 8'(run_next);
                r_run                      <= '0;
            end else begin
                r_run <= run_next;
            end
        end
    end

endmodule

@@ hw/rtl/rssi_report_frame_builder_unit.sv @@
// rssi_report_frame_builder_unit: top level of the signal-strength report frame builder
// a report item runs through the accept, crc, cobs and send phases in that order
// one item at a time: a report holds the block until its last frame byte is taken,
// and the send phase stalls while the receiver is not ready; a record or a refused
// report leaves the block idle. the serial crc step and the one-byte-a-cycle cobs pass
// set how long a report takes. reset: synchronous active low; clears pointer, strength store and registers to defaults
module rssi_report_frame_builder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rrfb_in_if.sink                       i_rpt,
    rrfb_out_if.source                    o_frm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrfb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration registers
    logic [7:0] r_own_id;
    logic [4:0] r_node_count;
    logic       cfg_wr;
    logic       cfg_sel;

    // controller to datapath
    rrfb_pkg::t_dp_cmd    dp_cmd;
    rrfb_pkg::t_dp_status dp_status;

    assign pready  = 1'b1;
    // register index is the word address; byte offset bits are ignored
    assign cfg_sel = paddr[rrfb_pkg::ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= '0;
            r_node_count <= rrfb_pkg::NODE_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                rrfb_pkg::REG_OWN_ID:     r_own_id     <= pwdata[7:0];
                rrfb_pkg::REG_NODE_COUNT: r_node_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (cfg_sel)
            rrfb_pkg::REG_OWN_ID:     prdata = {24'h0, r_own_id};
            rrfb_pkg::REG_NODE_COUNT: prdata = {27'h0, r_node_count};
            default:                  prdata = '0;
        endcase
    end

    // sequencer: holds the phase and the byte counter
    rrfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rpt.valid),
        .o_in_ready  (i_rpt.ready),
        .o_out_valid (o_frm.valid),
        .o_out_last  (o_frm.last),
        .i_out_ready (o_frm.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // store, pointer, frame buffer; the frame byte is read straight from the buffer,
    // which holds still for the whole send phase
    rrfb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_mode       (i_rpt.mode),
        .i_node       (i_rpt.node),
        .i_strength   (i_rpt.strength),
        .i_noise      (i_rpt.noise),
        .i_tx_space   (i_rpt.tx_space),
        .i_own_id     (r_own_id),
        .i_node_count (r_node_count),
        .o_frame_byte (o_frm.frame_byte)
    );

endmodule

@@ hw/rtl/rrfb_checker.sv @@
// rrfb_checker: port-level assertions for the report frame builder, bound to the top level
// depends on rssi_report_frame_builder_unit and rrfb_pkg
module rrfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_mode,
    input logic [9:0] i_in_tx_space,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a stalled frame byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)
                                           && $stable(i_out_last)))
        else $error("frame byte changed while stalled");

    // no new item is taken while a frame is being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during frame send");

    // the delimiter closes the frame
    a_end_of_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("output continues after delimiter");

    // a record or a report without room leaves the block idle
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready &&
         (i_in_mode == rrfb_pkg::MODE_RECORD || i_in_tx_space < rrfb_pkg::MIN_SPACE))
        |=> (i_in_ready && !i_out_valid))
        else $error("frame started without a valid report");

endmodule

bind rssi_report_frame_builder_unit rrfb_checker u_rrfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_rpt.valid),
    .i_in_ready    (i_rpt.ready),
    .i_in_mode     (i_rpt.mode),
    .i_in_tx_space (i_rpt.tx_space),
    .i_out_valid   (o_frm.valid),
    .i_out_ready   (o_frm.ready),
    .i_out_byte    (o_frm.frame_byte),
    .i_out_last    (o_frm.last)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for rssi_report_frame_builder_unit, frame bytes predicted per item
// depends on rrfb_pkg, rrfb_in_if, rrfb_out_if and the top level of the block
module testbench;

    import rrfb_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 32;
    localparam int END_CYCLES   = 40;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the pressure test
    localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake before giving up
    localparam int SHOWN_ERRORS = 10;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } t_sink_style;

    typedef struct packed {
        logic       mode;
        logic [3:0] node;
        logic [7:0] strength;
        logic [7:0] noise;
        logic [9:0] tx_space;
    } t_request;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_frame_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rrfb_in_if  rpt_if ();
    rrfb_out_if frm_if ();

    rssi_report_frame_builder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rpt   (rpt_if),
        .o_frm   (frm_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predicted block state, kept alongside the block
    logic [7:0]  own_id     = 8'd0;
    logic [4:0]  node_count = NODE_COUNT_RESET;
    int          node_ptr   = 0;
    logic [7:0]  strengths [MAX_NODES];

    // frame bytes still owed by the block, oldest first
    t_frame_beat pending_frame_bytes [$];
    int          mismatches = 0;

    // sender burst shaping and receiver stall control
    logic        gaps_on    = 1'b1;
    int          burst_left = 0;
    t_sink_style sink_style = SINK_RANDOM;
    logic        holdoff_request = 1'b0;

    // ---------------------------------------------------------------
    // frame prediction
    // ---------------------------------------------------------------

    // x.25 style byte update of the running crc
    function automatic logic [15:0] crc_mix(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] t;
        t = {8'h00, data ^ crc[7:0]};
        t = {8'h00, t[7:0] ^ {t[3:0], 4'h0}};
        return (crc >> 8) ^ (t << 8) ^ (t << 3) ^ (t >> 4);
    endfunction

    // advance the round-robin pointer, build the message, crc and cobs, queue ten bytes, clear the entry
    function automatic void predict_frame(input logic [7:0] noise);
        logic [7:0]  msg [FRAME_LEN];
        logic [15:0] crc;
        int          p;
        int          run;
        t_frame_beat beat;
        p = node_ptr + 1;
        // own id is skipped once, before the wrap test
        if (p == own_id)
            p++;
        if (p >= node_count || p >= MAX_NODES)
            p = 0;
        node_ptr = p;
        msg[0] = 8'h00;
        msg[1] = HDR_START;
        msg[2] = own_id;
        msg[3] = HDR_MSG_ID;
        msg[4] = p[7:0];
        msg[5] = strengths[p];
        msg[6] = noise;
        crc = CRC_SEED;
        for (int i = 1; i <= 6; i++)
            crc = crc_mix(crc, msg[i]);
        crc = crc_mix(crc, CRC_EXTRA);
        msg[7] = crc[7:0];
        msg[8] = crc[15:8];
        msg[9] = 8'h00;
        // cobs: the lead byte and every zero but the closing delimiter hold the distance to the next zero
        run = 0;
        for (int i = 1; i < FRAME_LEN; i++) begin
            run++;
            if (msg[i] == 8'h00) begin
                msg[i - run] = run[7:0];
                run = 0;
            end
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            beat.frame_byte = msg[i];
            beat.last       = (i == FRAME_LEN - 1);
            pending_frame_bytes.push_back(beat);
        end
        strengths[p] = 8'h00;
    endfunction

    // effect of one accepted item on the predicted state
    function automatic void apply_request(input t_request req);
        if (req.mode == MODE_RECORD) begin
            strengths[req.node] = req.strength;
        end else if (req.tx_space >= MIN_SPACE) begin
            predict_frame(req.noise);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     mismatches, $realtime, what, want, got);
    endfunction

    // ---------------------------------------------------------------
    // frame byte checker, samples at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && frm_if.valid && frm_if.ready) begin
            if (pending_frame_bytes.size() == 0) begin
                note_mismatch("unexpected frame byte", 32'h0, {23'h0, frm_if.last,
                              frm_if.frame_byte});
            end else begin
                want = pending_frame_bytes.pop_front();
                if (frm_if.frame_byte !== want.frame_byte)
                    note_mismatch("frame_byte", 32'(want.frame_byte),
                                  32'(frm_if.frame_byte));
                if (frm_if.last !== want.last)
                    note_mismatch("last", 32'(want.last), 32'(frm_if.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall style chosen per test, plus an occasional long hold-off
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        static int hold_left = 0;
        static int pat_cnt   = 0;
        if (holdoff_request) begin
            hold_left       = HOLD_CYCLES;
            holdoff_request = 1'b0;
        end
        pat_cnt = (pat_cnt + 1) % 7;
        if (hold_left > 0) begin
            hold_left--;
            frm_if.ready = 1'b0;
        end else begin
            case (sink_style)
                SINK_ALWAYS: begin
                    frm_if.ready = 1'b1;
                end
                SINK_RANDOM: begin
                    frm_if.ready = ($urandom_range(0, 99) < 65);
                end
                default: begin
                    // uneven fixed pattern: ready drops at steps 2, 4 and 5 of the pattern counter
                    frm_if.ready = !(pat_cnt == 2 || pat_cnt == 4 || pat_cnt == 5);
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no handshake on any port
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        static int quiet = 0;
        if ((rpt_if.valid && rpt_if.ready) || (frm_if.valid && frm_if.ready) ||
            (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sender and register access
    // ---------------------------------------------------------------

    // offer one item, with a random gap first when a burst has run out
    task automatic send_request(input t_request req);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            rpt_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        rpt_if.valid    = 1'b1;
        rpt_if.mode     = req.mode;
        rpt_if.node     = req.node;
        rpt_if.strength = req.strength;
        rpt_if.noise    = req.noise;
        rpt_if.tx_space = req.tx_space;
        do
            @(posedge i_clk);
        while (!rpt_if.ready);
        apply_request(req);
        if (burst_left > 0)
            burst_left--;
    endtask

    // unused fields carry random filler so that their bits move too
    task automatic send_record(input logic [3:0] node, input logic [7:0] strength);
        t_request req;
        req          = t_request'({$urandom, $urandom});
        req.mode     = MODE_RECORD;
        req.node     = node;
        req.strength = strength;
        send_request(req);
    endtask

    task automatic send_report(input logic [7:0] noise, input logic [9:0] tx_space);
        t_request req;
        req          = t_request'({$urandom, $urandom});
        req.mode     = MODE_REPORT;
        req.noise    = noise;
        req.tx_space = tx_space;
        send_request(req);
    endtask

    // stop offering, let every owed byte arrive, then allow for a record still in flight
    task automatic settle_block();
        @(negedge i_clk);
        rpt_if.valid = 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write of one register followed by a read-back of its field
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] mask;
        mask = (reg_sel == REG_OWN_ID) ? 32'hFF : 32'h1F;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({reg_sel, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (reg_sel == REG_OWN_ID)
            own_id = value[7:0];
        else
            node_count = value[4:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (value & mask))
            note_mismatch("register read-back", value & mask, prdata & mask);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // upper write data bits are junk that the register must drop
    task automatic configure(input logic [7:0] own, input logic [4:0] count);
        logic [31:0] junk;
        settle_block();
        junk = $urandom;
        write_register(REG_OWN_ID, {junk[31:8], own});
        junk = $urandom;
        write_register(REG_NODE_COUNT, {junk[31:5], count});
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values: own id 0, a single node, so every report names node 0
    task automatic test_reset_defaults();
        sink_style = SINK_RANDOM;
        gaps_on    = 1'b1;
        send_record(4'd0, 8'hFF);
        send_report(8'h00, MIN_SPACE);      // room just enough, zero noise in the payload
        send_report(8'hFF, MIN_SPACE - 1);  // one byte short: refused, no state change
        send_report(8'h55, 10'd0);
        send_record(4'hF, 8'hAA);
        send_report(8'hAA, 10'h3FF);        // node 0 again, its entry now cleared
    endtask

    // own id skip, wrap at node count, zero node count and a skip of the first node
    task automatic test_pointer_rules();
        configure(8'd2, 5'd4);
        send_record(4'd1, 8'h01);
        send_record(4'd3, 8'h80);
        send_report(8'h0F, 10'd512);        // node 1
        send_report(8'hF0, 10'd11);         // node 2 is our own, so node 3
        send_report(8'h00, 10'd1000);       // wraps to 0
        send_report(8'h33, 10'd10);         // node 1, cleared by the first report
        configure(8'd0, 5'd0);
        send_record(4'd0, 8'h7E);
        send_report(8'h81, 10'd700);        // a zero node count always gives node 0
        configure(8'd1, 5'd31);
        send_record(4'd2, 8'h00);
        send_report(8'h00, 10'd255);        // pointer 0 steps onto our own id, lands on 2
    endtask

    // random records and reports under one setting
    task automatic test_random_traffic(input logic [7:0] own, input logic [4:0] count,
                                       input t_sink_style style, input logic gaps,
                                       input int n_items);
        logic [7:0] value;
        logic [9:0] space;
        configure(own, count);
        sink_style = style;
        gaps_on    = gaps;
        burst_left = 0;
        for (int i = 0; i < n_items; i++) begin
            value = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
            if ($urandom_range(0, 99) < 45) begin
                send_record(4'($urandom), value);
            end else begin
                // mostly room for a frame, now and then a refusal
                if ($urandom_range(0, 9) == 0)
                    space = 10'($urandom_range(0, 9));
                else
                    space = 10'($urandom_range(10, 1023));
                send_report(value, space);
            end
        end
    endtask

    // receiver holds off for a long stretch while reports keep coming, so the input stalls
    task automatic test_output_holdoff();
        configure(8'd5, 5'd9);
        sink_style      = SINK_ALWAYS;
        gaps_on         = 1'b0;
        holdoff_request = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 0)
                send_record(4'($urandom_range(0, 8)), 8'($urandom));
            else
                send_report(8'($urandom), 10'($urandom_range(10, 1023)));
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_NODES; i++)
            strengths[i] = 8'h00;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rpt_if.valid    = 1'b0;
        rpt_if.mode     = MODE_RECORD;
        rpt_if.node     = '0;
        rpt_if.strength = '0;
        rpt_if.noise    = '0;
        rpt_if.tx_space = '0;
        frm_if.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_pointer_rules();
        // a stretch with no idling on either side, widest id and full store
        test_random_traffic(8'd255, 5'd16, SINK_ALWAYS, 1'b0, 60);
        test_random_traffic(8'd0, 5'd1, SINK_RANDOM, 1'b1, 60);
        test_random_traffic(8'($urandom_range(0, 17)), 5'($urandom_range(0, 31)),
                            SINK_PATTERN, 1'b1, 60);
        // node count above the store depth wraps at the store depth
        test_random_traffic(8'd15, 5'd31, SINK_RANDOM, 1'b0, 60);
        test_random_traffic(8'($urandom), 5'($urandom_range(1, 16)), SINK_RANDOM, 1'b1, 60);
        test_random_traffic(8'd3, 5'd0, SINK_PATTERN, 1'b1, 40);
        test_output_holdoff();

        @(negedge i_clk);
        rpt_if.valid = 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_frame_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rrfb_pkg.sv
hw/rtl/rrfb_in_if.sv
hw/rtl/rrfb_out_if.sv
hw/rtl/rrfb_ctrl.sv
hw/rtl/rrfb_datapath.sv
hw/rtl/rssi_report_frame_builder_unit.sv
hw/rtl/rrfb_checker.sv
tb/sv/testbench.sv
